/* rtl/odi_pkg.sv */
package odi_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int ATAN_LEN     = 30;
    localparam int NUM_ITER     = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int ITER_W       = $clog2(ATAN_LEN);

    localparam int TRAVEL_W = 24;
    localparam int ACC_W    = 32;
    localparam int CORDIC_W = 33;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic signed [CORDIC_W-1:0] CORDIC_K_Q30 = 33'sd652032874;
    localparam logic [ACC_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ACC_W-1:0] HALF_TURN    = 32'h8000_0000;

    localparam logic [ACC_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41721,
        32'd20860,     32'd10430,     32'd5215,      32'd2607,     32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81,       32'd40,
        32'd20,        32'd10,        32'd5,         32'd2,        32'd1
    };

    typedef struct packed {
        logic signed [TRAVEL_W-1:0] right_travel;
        logic signed [TRAVEL_W-1:0] left_travel;
    } odi_in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] pos_x;
        logic signed [ACC_W-1:0] pos_y;
        logic        [ACC_W-1:0] heading_out;
    } odi_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_H,
        ST_WRITE
    } odi_state_t;

    typedef enum logic [1:0] {
        CD_IDLE,
        CD_ROTATE,
        CD_FIX
    } odi_cd_state_t;

endpackage

/* rtl/odi_cordic.sv */
module odi_cordic
    import odi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ACC_W-1:0]           angle,
    output logic                       done,
    output logic signed [CORDIC_W-1:0] sin_val,
    output logic signed [CORDIC_W-1:0] cos_val
);

    odi_cd_state_t state_reg, state_next;
    logic [ITER_W-1:0]           cnt_reg;
    logic                        flip_reg;
    logic signed [CORDIC_W-1:0]  cx_reg, cy_reg, z_reg;

    logic [ACC_W-1:0]            ang_sum, ang_red;
    logic signed [CORDIC_W-1:0]  dx_shift, dy_shift, atan_ext;
    logic                        last_iter;

    always_comb
    begin
        ang_sum   = angle + QUARTER_TURN;
        ang_red   = ang_sum[ACC_W-1] ? (angle + HALF_TURN) : angle;
        dx_shift  = cy_reg >>> cnt_reg;
        dy_shift  = cx_reg >>> cnt_reg;
        atan_ext  = $signed({1'b0, ATAN_TURNS[cnt_reg]});
        last_iter = (cnt_reg == ITER_W'(NUM_ITER - 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CD_IDLE:
            begin
                if (start)
                    state_next = CD_ROTATE;
            end
            CD_ROTATE:
            begin
                if (last_iter)
                    state_next = CD_FIX;
            end
            CD_FIX:
            begin
                state_next = CD_IDLE;
            end
            default:
            begin
                state_next = CD_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        done    = (state_reg == CD_FIX);
        sin_val = cy_reg;
        cos_val = cx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CD_ROTATE)
                cnt_reg <= cnt_reg + ITER_W'(1);
            else
                cnt_reg <= '0;
        end
    end

    // datapath: one micro-rotation per cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            CD_IDLE:
            begin
                if (start)
                begin
                    flip_reg <= ang_sum[ACC_W-1];
                    cx_reg   <= CORDIC_K_Q30;
                    cy_reg   <= '0;
                    z_reg    <= $signed({ang_red[ACC_W-1], ang_red});
                end
            end
            CD_ROTATE:
            begin
                if (!z_reg[CORDIC_W-1])
                begin
                    cx_reg <= cx_reg - dx_shift;
                    cy_reg <= cy_reg + dy_shift;
                    z_reg  <= z_reg - atan_ext;
                end
                else
                begin
                    cx_reg <= cx_reg + dx_shift;
                    cy_reg <= cy_reg - dy_shift;
                    z_reg  <= z_reg + atan_ext;
                end
            end
            CD_FIX:
            begin
                if (flip_reg)
                begin
                    cx_reg <= -cx_reg;
                    cy_reg <= -cy_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/odi_mul.sv */
module odi_mul
    import odi_pkg::*;
(
    input  logic                      clk,
    input  logic                      load,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg, prod_next;

    always_comb
    begin
        prod_next = PROD_W'(op_a) * PROD_W'(op_b);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

/* rtl/differential_odometry_integrator.sv */
// an input transaction passes through ST_ROTATE, ST_MUL_X, ST_MUL_Y, ST_MUL_H and ST_WRITE
// before its result is valid; a new input is taken only in ST_IDLE; each transaction runs the
//   one-rotation-per-cycle CORDIC loop and the single shared multiplier used three times
// a finished result waits in the output register while the next input is taken
// reset: rst_n asynchronous active low clears x, y, heading and heading_gain to zero
module differential_odometry_integrator
    import odi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wheel_valid,
    output logic        wheel_stall,
    input  odi_in_t     wheel,
    output logic        pose_valid,
    input  logic        pose_stall,
    output odi_out_t    pose,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam logic [PROD_W+4:0] ROUND_POS = (PROD_W+5)'(1) << 30;

    odi_state_t state_reg, state_next;

    logic [ACC_W-1:0]          gain_reg;
    logic [ACC_W-1:0]          x_acc_reg, y_acc_reg, heading_acc_reg;
    logic signed [MUL_B_W-1:0] diff_reg, sum_reg;
    logic [ACC_W-1:0]          dx_reg, dy_reg;
    logic                      pose_valid_reg;
    odi_out_t                  pose_reg;

    logic                      accept, out_free, write_en;
    logic                      cordic_start, cordic_done;
    logic signed [CORDIC_W-1:0] sin_val, cos_val;
    logic                      mul_load;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W+4:0]         pos_rnd;
    logic [47:0]               head_rnd;
    logic [ACC_W-1:0]          d_pos, d_head;

    odi_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (heading_acc_reg),
        .done    (cordic_done),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    odi_mul u_mul (
        .clk  (clk),
        .load (mul_load),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign accept   = wheel_valid && !wheel_stall;
    assign out_free = !pose_valid_reg || !pose_stall;

    // round half up of the product
    always_comb
    begin
        pos_rnd  = {{5{prod[PROD_W-1]}}, prod} + ROUND_POS;
        d_pos    = pos_rnd[62:31];
        head_rnd = prod[47:0] + 48'h0000_0000_8000;
        d_head   = head_rnd[47:16];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (wheel_valid)
                    state_next = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                if (cordic_done)
                    state_next = ST_MUL_X;
            end
            ST_MUL_X:
            begin
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y:
            begin
                state_next = ST_MUL_H;
            end
            ST_MUL_H:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        wheel_stall  = 1'b1;
        cordic_start = 1'b0;
        mul_load     = 1'b0;
        write_en     = 1'b0;
        op_a         = '0;
        op_b         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                wheel_stall  = 1'b0;
                cordic_start = wheel_valid;
            end
            ST_ROTATE:
            begin
            end
            ST_MUL_X:
            begin
                mul_load = 1'b1;
                op_a     = sin_val;
                op_b     = diff_reg;
            end
            ST_MUL_Y:
            begin
                mul_load = 1'b1;
                op_a     = cos_val;
                op_b     = diff_reg;
            end
            ST_MUL_H:
            begin
                mul_load = 1'b1;
                op_a     = $signed({1'b0, gain_reg});
                op_b     = sum_reg;
            end
            ST_WRITE:
            begin
                write_en = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gain_reg        <= '0;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            heading_acc_reg <= '0;
            pose_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                gain_reg <= cfg_data;
            if (write_en)
            begin
                x_acc_reg       <= x_acc_reg + dx_reg;
                y_acc_reg       <= y_acc_reg + dy_reg;
                heading_acc_reg <= heading_acc_reg + d_head;
                pose_valid_reg  <= 1'b1;
            end
            else if (!pose_stall)
            begin
                pose_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_reg <= MUL_B_W'(wheel.right_travel) - MUL_B_W'(wheel.left_travel);
            sum_reg  <= MUL_B_W'(wheel.right_travel) + MUL_B_W'(wheel.left_travel);
        end
        if (state_reg == ST_MUL_Y)
            dx_reg <= d_pos;
        if (state_reg == ST_MUL_H)
            dy_reg <= d_pos;
        if (write_en)
        begin
            pose_reg.pos_x       <= x_acc_reg + dx_reg;
            pose_reg.pos_y       <= y_acc_reg + dy_reg;
            pose_reg.heading_out <= heading_acc_reg + d_head;
        end
    end

    assign cfg_ready  = 1'b1;
    assign pose_valid = pose_valid_reg;
    assign pose       = pose_reg;

endmodule
